/* rtl/core/hmst_pkg.sv */
// shared types and byte constants for the html markup state tracker
package hmst_pkg;

  typedef enum logic [3:0] {
    ST_TEXT   = 4'd0,
    ST_TAG0   = 4'd1,
    ST_TAG    = 4'd2,
    ST_EQL    = 4'd3,
    ST_QUOTE  = 4'd4,
    ST_DQUOTE = 4'd5,
    ST_VALUE  = 4'd6,
    ST_AMP    = 4'd7,
    ST_CMNT1  = 4'd8,
    ST_CMNT2  = 4'd9,
    ST_CMNT   = 4'd10,
    ST_NCMNT1 = 4'd11,
    ST_NCMNT2 = 4'd12,
    ST_NCMNT3 = 4'd13,
    ST_IRRTAG = 4'd14,
    ST_EOL    = 4'd15
  } lex_state_e;

  typedef struct packed {
    logic       is_text;
    lex_state_e state;
  } hmst_res_t;

  localparam logic [7:0] ChLt     = 8'h3C;  // '<'
  localparam logic [7:0] ChAmp    = 8'h26;  // '&'
  localparam logic [7:0] ChBang   = 8'h21;  // '!'
  localparam logic [7:0] ChGt     = 8'h3E;  // '>'
  localparam logic [7:0] ChEq     = 8'h3D;  // '='
  localparam logic [7:0] ChSemi   = 8'h3B;  // ';'
  localparam logic [7:0] ChHash   = 8'h23;  // '#'
  localparam logic [7:0] ChUnder  = 8'h5F;  // '_'
  localparam logic [7:0] ChDash   = 8'h2D;  // '-'
  localparam logic [7:0] ChUpperD = 8'h44;  // 'D'
  localparam logic [7:0] ChLowerD = 8'h64;  // 'd'
  localparam logic [7:0] ChDquote = 8'h22;  // '"'
  localparam logic [7:0] ChSquote = 8'h27;  // single quote
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  function automatic logic ch_is_blank(input logic [7:0] c);
    return ((c >= ChTab) && (c <= ChCr)) || (c == ChSpace);
  endfunction

  function automatic logic ch_is_word(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

/* rtl/core/hmst_next.sv */
// next-state and text-flag logic for one byte
module hmst_next import hmst_pkg::*; (
  input  lex_state_e  state_i,
  input  logic [7:0]  byte_i,
  output hmst_res_t   res_o
);

  lex_state_e tag_nxt;

  always_comb begin
    if (byte_i == ChGt) begin
      tag_nxt = ST_TEXT;
    end else if (byte_i == ChEq) begin
      tag_nxt = ST_EQL;
    end else begin
      tag_nxt = ST_TAG;
    end
  end

  always_comb begin
    res_o.is_text = 1'b0;
    res_o.state   = state_i;
    case (state_i)
      ST_TEXT: begin
        if (byte_i == ChLt) begin
          res_o.state = ST_TAG0;
        end else begin
          res_o.is_text = 1'b1;
          if (byte_i == ChAmp) res_o.state = ST_AMP;
        end
      end
      ST_TAG0: begin
        res_o.state = (byte_i == ChBang) ? ST_CMNT1 : tag_nxt;
      end
      ST_TAG: res_o.state = tag_nxt;
      ST_EQL: begin
        if (byte_i == ChDquote)       res_o.state = ST_DQUOTE;
        else if (byte_i == ChSquote)  res_o.state = ST_QUOTE;
        else if (ch_is_blank(byte_i)) res_o.state = ST_EQL;
        else if (byte_i == ChGt)      res_o.state = ST_TEXT;
        else                          res_o.state = ST_VALUE;
      end
      ST_QUOTE: begin
        if (byte_i == ChSquote) res_o.state = ST_TAG;
      end
      ST_DQUOTE: begin
        if (byte_i == ChDquote) res_o.state = ST_TAG;
      end
      ST_VALUE: begin
        if (byte_i == ChGt)            res_o.state = ST_TEXT;
        else if (ch_is_blank(byte_i))  res_o.state = ST_TAG;
      end
      ST_AMP: begin
        if ((byte_i == ChSemi) ||
            ((byte_i != ChHash) && (byte_i != ChUnder) && !ch_is_word(byte_i))) begin
          res_o.state = ST_TEXT;
        end
      end
      ST_CMNT1: begin
        if (byte_i == ChDash)    res_o.state = ST_CMNT2;
        else if (byte_i == ChGt) res_o.state = ST_TEXT;
        else if ((byte_i == ChUpperD) || (byte_i == ChLowerD)) res_o.state = ST_TAG;
        else                     res_o.state = ST_IRRTAG;
      end
      ST_CMNT2: begin
        if (byte_i == ChDash)    res_o.state = ST_CMNT;
        else if (byte_i == ChGt) res_o.state = ST_TEXT;
        else                     res_o.state = ST_IRRTAG;
      end
      ST_CMNT: begin
        if (byte_i == ChDash) res_o.state = ST_NCMNT1;
      end
      ST_NCMNT1: begin
        res_o.state = (byte_i == ChDash) ? ST_NCMNT2 : ST_CMNT;
      end
      ST_NCMNT2: begin
        if (byte_i == ChGt)            res_o.state = ST_TEXT;
        else if (byte_i == ChDash)     res_o.state = ST_NCMNT2;
        else if (ch_is_blank(byte_i))  res_o.state = ST_NCMNT3;
        else                           res_o.state = ST_CMNT;
      end
      ST_NCMNT3: begin
        if (byte_i == ChGt)            res_o.state = ST_TEXT;
        else if (byte_i == ChDash)     res_o.state = ST_NCMNT1;
        else if (ch_is_blank(byte_i))  res_o.state = ST_NCMNT3;
        else                           res_o.state = ST_CMNT;
      end
      ST_IRRTAG: begin
        if (byte_i == ChGt) res_o.state = ST_TEXT;
      end
      default: res_o.state = ST_EOL;
    endcase
  end

endmodule

/* rtl/core/html_markup_state_tracker.sv */
// top level of the html markup lexical state tracker
//
// usage
//   input channel: in_valid_i / in_ready_o carry one byte_in_i per transfer
//   output channel: out_valid_o / out_ready_i carry one result per input byte,
//   is_text_o (byte is text content) and lex_state_o (state after the byte)
//   results leave in the same order as the bytes came in, exactly one each
// throughput
//   the byte lands in an input register, the state update logic sits between
//   it and the result register, so the result is registered; one byte per
//   clock sustained while bytes keep coming and out_ready_i stays high, with
//   the state fed back through the mode register
// stall behavior
//   when the receiver holds out_ready_i low the result register holds, the
//   input register fills, and in_ready_o drops only once both are full
// reset
//   rst_ni clears both valid flags and puts the lexer into text state
module html_markup_state_tracker import hmst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_text_o,
  output logic [3:0] lex_state_o
);

  // input stage
  logic       in_vld_q;
  logic [7:0] byte_q;

  // lexer mode and result stage
  lex_state_e mode_q;
  logic       out_vld_q;
  hmst_res_t  res_q;
  hmst_res_t  res_d;

  logic out_free;
  logic advance;

  // result register can take a new value when empty or being drained
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || advance;

  hmst_next u_next (
    .state_i (mode_q),
    .byte_i  (byte_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= ST_TEXT;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (out_free)   out_vld_q <= in_vld_q;
      // state moves only when a byte is consumed into the result stage
      if (advance)    mode_q <= res_d.state;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) byte_q <= byte_in_i;
    if (advance)                  res_q  <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign is_text_o   = res_q.is_text;
  assign lex_state_o = res_q.state;

endmodule

/* rtl/core/hmst_checker.sv */
// port-level checks for the html markup state tracker, with bind
module hmst_checker import hmst_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       is_text_o,
  input logic [3:0] lex_state_o
);

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(is_text_o) && $stable(lex_state_o))
    else $error("result changed while stalled");

  // end-of-line state is unreachable from reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lex_state_o != ST_EOL)
    else $error("end-of-line state reached");

  // a text byte leaves the lexer in text or entity state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_text_o |-> (lex_state_o == ST_TEXT) || (lex_state_o == ST_AMP))
    else $error("text byte with non-text next state");

endmodule

bind html_markup_state_tracker hmst_checker u_hmst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .is_text_o   (is_text_o),
  .lex_state_o (lex_state_o)
);
